// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL (pre_fifo includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== src/pre_pkg.sv =====
package pre_pkg;
	localparam int GUARD = 8;
	localparam int ANG_W = 33;
	localparam logic [31:0] GAIN_INV = 32'd2608131496;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 33'sd1073741824;
	localparam logic signed [ANG_W-1:0] HALF_TURN_S = 33'sd2147483648;

	// degree/64 to binary angle: 2^32/23040 = 2^23/45
	localparam logic [17:0] DIV_OFS = 18'd32805;
	localparam logic [11:0] DIV_BIAS = 12'd729;
	localparam logic [33:0] RECIP45 = 34'd93207;
	localparam logic [23:0] FRAC_STEP = 24'd186413;
	localparam logic [21:0] FRAC_RECIP = 22'd1457;

	function automatic logic [31:0] atan_lut(input logic [4:0] k);
		case (k)
			5'd0: return 32'd536870912;
			5'd1: return 32'd316933406;
			5'd2: return 32'd167458907;
			5'd3: return 32'd85004756;
			5'd4: return 32'd42667331;
			5'd5: return 32'd21354465;
			5'd6: return 32'd10679838;
			5'd7: return 32'd5340245;
			5'd8: return 32'd2670163;
			5'd9: return 32'd1335087;
			5'd10: return 32'd667544;
			5'd11: return 32'd333772;
			5'd12: return 32'd166886;
			5'd13: return 32'd83443;
			5'd14: return 32'd41722;
			5'd15: return 32'd20861;
			5'd16: return 32'd10430;
			5'd17: return 32'd5215;
			5'd18: return 32'd2608;
			5'd19: return 32'd1304;
			5'd20: return 32'd652;
			5'd21: return 32'd326;
			5'd22: return 32'd163;
			5'd23: return 32'd81;
			5'd24: return 32'd41;
			5'd25: return 32'd20;
			5'd26: return 32'd10;
			5'd27: return 32'd5;
			5'd28: return 32'd3;
			5'd29: return 32'd1;
			5'd30: return 32'd1;
			default: return 32'd0;
		endcase
	endfunction
endpackage

// ===== src/pre_fifo.sv =====
`include "assert_macros.svh"
module pre_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= (AW+1)'(DEPTH))
	`ASSERT_NXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`ASSERT_NXT(a_cnt_dn, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 1'b1)
endmodule

// ===== src/pre_front.sv =====
module pre_front #(
	parameter int CW = 24,
	parameter int IW = 36
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic signed [CW-1:0]      x_in,
	input  logic signed [CW-1:0]      y_in,
	input  logic signed [CW-1:0]      z_in,
	input  logic signed [CW-1:0]      e_in,
	input  logic signed [15:0]        angle_change,
	input  logic signed [CW-1:0]      radius_change,
	output logic                      item_valid,
	input  logic                      item_ready,
	output logic [2*IW+3*CW+33:0]     item
);
	import pre_pkg::*;

	typedef struct packed {
		logic signed [IW-1:0] u;
		logic signed [IW-1:0] v;
		logic                 half;
		logic                 org;
		logic signed [CW-1:0] dr;
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] e;
	} car_t;

	car_t car_d, car_s1, car_s2, car_s3, car_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en;
	logic signed [IW-1:0] xe, ye;
	logic [17:0] dsum;
	logic [16:0] dp_s1;
	logic [33:0] p1_s1;
	logic [11:0] qp, qp_s2, qp_s3;
	logic [5:0] rd_s2;
	logic [10:0] tt;
	logic [21:0] t1_s3;
	logic [23:0] rdm_s3;
	logic [31:0] dth_s4;

	assign en = !vld_s4 || item_ready;
	assign req_ready = en;
	assign item_valid = vld_s4;
	assign item = {car_s4, dth_s4};

	always_comb begin
		xe = IW'(x_in) <<< GUARD;
		ye = IW'(y_in) <<< GUARD;
		car_d.org = (x_in == '0) && (y_in == '0);
		car_d.half = ye < 0;
		car_d.u = car_d.half ? -ye : ye;
		car_d.v = car_d.half ? -xe : xe;
		car_d.dr = radius_change;
		car_d.z = z_in;
		car_d.e = e_in;
		dsum = 18'(angle_change) + DIV_OFS;
		qp = p1_s1[33:22];
		tt = 11'(rd_s2) * 11'd23 + 11'd22;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s1 <= car_d;
			dp_s1 <= dsum[16:0];
			p1_s1 <= 34'(dsum[16:0]) * RECIP45;
			car_s2 <= car_s1;
			qp_s2 <= qp;
			rd_s2 <= 6'(dp_s1 - 17'(qp) * 17'd45);
			car_s3 <= car_s2;
			qp_s3 <= qp_s2;
			t1_s3 <= 22'(tt) * FRAC_RECIP;
			rdm_s3 <= 24'(rd_s2) * FRAC_STEP;
			car_s4 <= car_s3;
			dth_s4 <= {9'(qp_s3 - DIV_BIAS), 23'd0} + 32'(rdm_s3) + 32'(t1_s3[21:16]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end
endmodule

// ===== src/pre_back.sv =====
module pre_back #(
	parameter int CW = 24,
	parameter int IW = 36,
	parameter int STAGES = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [2*IW+3*CW+33:0]     item,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic signed [CW-1:0]      x_out,
	output logic signed [CW-1:0]      y_out,
	output logic signed [CW-1:0]      z_out,
	output logic signed [CW-1:0]      e_out,
	output logic                      saturated
);
	import pre_pkg::*;

	typedef struct packed {
		logic signed [IW-1:0] u;
		logic signed [IW-1:0] v;
		logic                 half;
		logic                 org;
		logic signed [CW-1:0] dr;
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] e;
	} car_t;

	typedef struct packed {
		logic                 org;
		logic [31:0]          dth;
		logic signed [CW-1:0] dr;
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] e;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] e;
	} pass_t;

	car_t ci;
	logic [31:0] dthi;
	logic en;

	logic signed [IW-1:0] vu_s [STAGES];
	logic signed [IW-1:0] vv_s [STAGES];
	logic [31:0] vt_s [STAGES];
	side_t vsd_s [STAGES];
	logic vval_s [STAGES];

	logic signed [IW-1:0] ru_s [STAGES];
	logic signed [IW-1:0] rv_s [STAGES];
	logic signed [ANG_W-1:0] ra_s [STAGES];
	pass_t rpd_s [STAGES];
	logic rval_s [STAGES];

	logic [IW+15:0] hg_s1, hg_s3;
	logic [31:0] lg_s1, lg_s3;
	logic [31:0] th_s1, th_s2;
	logic signed [CW-1:0] dr_s1;
	pass_t pd_s1, pd_s2, pd_s3, pd_s4;
	logic signed [IW-1:0] r_s2, s_s4;
	logic sgn_s3;
	logic signed [ANG_W-1:0] a_s3, a_s4;
	logic val_s1, val_s2, val_s3, val_s4;

	logic signed [IW-1:0] uf;
	logic [IW-1:0] m1, m2;
	logic [47:0] lp1, lp2;
	logic [IW+16:0] sum1, sum2;
	logic signed [IW-1:0] p1, p2, r_n;
	logic neg;
	logic signed [ANG_W-1:0] a_n, af;
	logic [CW:0] fx, fy;

	logic signed [CW-1:0] x_q, y_q, z_q, e_q;
	logic sat_q, out_vld_q;

	function automatic logic [CW:0] finish_f(input logic signed [IW-1:0] v);
		logic signed [IW-1:0] rnd, w, hi, lo;
		rnd = IW'(1) <<< (GUARD-1);
		hi = (IW'(1) <<< (CW-1)) - IW'(1);
		lo = -hi - rnd + rnd - IW'(1);
		w = (v + rnd) >>> GUARD;
		if (w > hi) begin
			return {1'b1, hi[CW-1:0]};
		end else if (w < lo) begin
			return {1'b1, lo[CW-1:0]};
		end
		return {1'b0, w[CW-1:0]};
	endfunction

	assign {ci, dthi} = item;
	assign en = !out_vld_q || rsp_ready;
	assign item_ready = en;

	for (genvar i = 0; i < STAGES; i++) begin : g_vec
		logic signed [IW-1:0] ui, vi;
		logic [31:0] ti;
		side_t si;
		logic vi_ok;
		if (i == 0) begin : g_first
			assign ui = ci.u;
			assign vi = ci.v;
			assign ti = ci.half ? HALF_TURN : 32'd0;
			assign si = '{org: ci.org, dth: dthi, dr: ci.dr, z: ci.z, e: ci.e};
			assign vi_ok = item_valid;
		end else begin : g_next
			assign ui = vu_s[i-1];
			assign vi = vv_s[i-1];
			assign ti = vt_s[i-1];
			assign si = vsd_s[i-1];
			assign vi_ok = vval_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (vi >= 0) begin
					vu_s[i] <= ui + (vi >>> i);
					vv_s[i] <= vi - (ui >>> i);
					vt_s[i] <= ti + atan_lut(5'(i));
				end else begin
					vu_s[i] <= ui - (vi >>> i);
					vv_s[i] <= vi + (ui >>> i);
					vt_s[i] <= ti - atan_lut(5'(i));
				end
				vsd_s[i] <= si;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vval_s[i] <= 1'b0;
			end else if (en) begin
				vval_s[i] <= vi_ok;
			end
		end
	end

	always_comb begin
		uf = (vsd_s[STAGES-1].org || vu_s[STAGES-1] < 0) ? '0 : vu_s[STAGES-1];
		m1 = uf;
		lp1 = 48'(m1[15:0]) * 48'(GAIN_INV);
		sum1 = (IW+17)'(hg_s1) + (IW+17)'(lg_s1);
		p1 = sum1[IW+15:16];
		r_n = p1 + (IW'(dr_s1) <<< GUARD);
		neg = r_s2 < 0;
		m2 = neg ? -r_s2 : r_s2;
		lp2 = 48'(m2[15:0]) * 48'(GAIN_INV);
		a_n = ANG_W'(signed'(th_s2));
		if (a_n > QUARTER_TURN) begin
			af = a_n - HALF_TURN_S;
		end else if (a_n < -QUARTER_TURN) begin
			af = a_n + HALF_TURN_S;
		end else begin
			af = a_n;
		end
		sum2 = (IW+17)'(hg_s3) + (IW+17)'(lg_s3);
		p2 = sum2[IW+15:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hg_s1 <= (IW+16)'(m1[IW-1:16]) * (IW+16)'(GAIN_INV);
			lg_s1 <= lp1[47:16];
			th_s1 <= (vsd_s[STAGES-1].org ? 32'd0 : vt_s[STAGES-1]) + vsd_s[STAGES-1].dth;
			dr_s1 <= vsd_s[STAGES-1].dr;
			pd_s1 <= '{z: vsd_s[STAGES-1].z, e: vsd_s[STAGES-1].e};
			r_s2 <= r_n;
			th_s2 <= th_s1;
			pd_s2 <= pd_s1;
			hg_s3 <= (IW+16)'(m2[IW-1:16]) * (IW+16)'(GAIN_INV);
			lg_s3 <= lp2[47:16];
			sgn_s3 <= neg ^ (af != a_n);
			a_s3 <= af;
			pd_s3 <= pd_s2;
			s_s4 <= sgn_s3 ? -p2 : p2;
			a_s4 <= a_s3;
			pd_s4 <= pd_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
		end else if (en) begin
			val_s1 <= vval_s[STAGES-1];
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		logic signed [IW-1:0] ui, vi;
		logic signed [ANG_W-1:0] ai, at;
		pass_t pi;
		logic vi_ok;
		assign at = signed'({1'b0, atan_lut(5'(i))});
		if (i == 0) begin : g_first
			assign ui = s_s4;
			assign vi = '0;
			assign ai = a_s4;
			assign pi = pd_s4;
			assign vi_ok = val_s4;
		end else begin : g_next
			assign ui = ru_s[i-1];
			assign vi = rv_s[i-1];
			assign ai = ra_s[i-1];
			assign pi = rpd_s[i-1];
			assign vi_ok = rval_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (ai >= 0) begin
					ru_s[i] <= ui - (vi >>> i);
					rv_s[i] <= vi + (ui >>> i);
					ra_s[i] <= ai - at;
				end else begin
					ru_s[i] <= ui + (vi >>> i);
					rv_s[i] <= vi - (ui >>> i);
					ra_s[i] <= ai + at;
				end
				rpd_s[i] <= pi;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rval_s[i] <= 1'b0;
			end else if (en) begin
				rval_s[i] <= vi_ok;
			end
		end
	end

	assign fx = finish_f(rv_s[STAGES-1]);
	assign fy = finish_f(ru_s[STAGES-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= fx[CW-1:0];
			y_q <= fy[CW-1:0];
			sat_q <= fx[CW] | fy[CW];
			z_q <= rpd_s[STAGES-1].z;
			e_q <= rpd_s[STAGES-1].e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= rval_s[STAGES-1];
		end
	end

	assign rsp_valid = out_vld_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
	assign e_out = e_q;
	assign saturated = sat_q;
endmodule

// ===== src/polar_rotate_and_extend.sv =====
// Polar move of a planar point: one beat in and one beat out per cycle when
// both sides keep up. A move passes four front stages that fold the point and
// convert angle_change to a binary angle, the four-entry queue, CORDIC_STAGES
// vectoring stages, four stages of gain correction and radius add,
// CORDIC_STAGES rotation stages and the output register. The back pipeline
// stalls as a whole on rsp_ready; the front keeps accepting until the queue
// is full.
module polar_rotate_and_extend #(
	parameter int COORD_WIDTH = 24,
	parameter int CORDIC_STAGES = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic signed [COORD_WIDTH-1:0] x_in,
	input  logic signed [COORD_WIDTH-1:0] y_in,
	input  logic signed [COORD_WIDTH-1:0] z_in,
	input  logic signed [COORD_WIDTH-1:0] e_in,
	input  logic signed [15:0]            angle_change,
	input  logic signed [COORD_WIDTH-1:0] radius_change,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic signed [COORD_WIDTH-1:0] z_out,
	output logic signed [COORD_WIDTH-1:0] e_out,
	output logic                          saturated
);
	import pre_pkg::*;

	localparam int IW = COORD_WIDTH + 12;
	localparam int ITEM_W = 2*IW + 3*COORD_WIDTH + 34;

	logic f_valid, f_ready, b_valid, b_ready;
	logic [ITEM_W-1:0] f_item, b_item;

	pre_front #(.CW(COORD_WIDTH), .IW(IW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.x_in(x_in), .y_in(y_in), .z_in(z_in), .e_in(e_in),
		.angle_change(angle_change), .radius_change(radius_change),
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	pre_fifo #(.W(ITEM_W), .DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_item),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_item)
	);

	pre_back #(.CW(COORD_WIDTH), .IW(IW), .STAGES(CORDIC_STAGES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.item_valid(b_valid), .item_ready(b_ready), .item(b_item),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.x_out(x_out), .y_out(y_out), .z_out(z_out), .e_out(e_out),
		.saturated(saturated)
	);
endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 24;
	localparam int STAGES = 20;
	localparam int LATENCY = 2 * STAGES + 10;
	localparam int G = 8;
	localparam longint TURN = 64'sd4294967296;
	localparam longint HALF = 64'sd2147483648;
	localparam longint QUARTER = 64'sd1073741824;
	localparam longint GAIN = 64'd2608131496;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] e;
		logic sat;
	} point_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] e;
		logic signed [15:0] da;
		logic signed [CW-1:0] dr;
	} move_t;

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_step(int k);
		longint t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
			20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
		return t[k];
	endfunction

	function automatic longint inv_gain(longint v);
		logic neg;
		longint unsigned m, h, l, p;
		neg = v < 0;
		m = neg ? -v : v;
		h = m >> 16;
		l = m & 64'hFFFF;
		p = (h * GAIN + ((l * GAIN) >> 16)) >> 16;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint clamp_out(longint v, ref logic sat);
		longint r, hi, lo;
		r = (v + (64'sd1 << (G - 1))) >>> G;
		hi = (64'sd1 <<< (CW - 1)) - 1;
		lo = -(64'sd1 <<< (CW - 1));
		if (r > hi) begin
			sat = 1;
			return hi;
		end
		if (r < lo) begin
			sat = 1;
			return lo;
		end
		return r;
	endfunction

	function automatic point_t polar_move(move_t m);
		longint u, v, th, num, q, r, s, a, nu, nv, rx, ry;
		logic sat;
		point_t p;
		u = longint'(m.y) * 256;
		v = longint'(m.x) * 256;
		th = 0;
		sat = 0;
		if (u < 0) begin
			u = -u;
			v = -v;
			th = HALF;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (v >= 0) begin
				nu = u + floor_shr(v, i);
				nv = v - floor_shr(u, i);
				th += atan_step(i);
			end else begin
				nu = u - floor_shr(v, i);
				nv = v + floor_shr(u, i);
				th -= atan_step(i);
			end
			u = nu;
			v = nv;
		end
		if (m.x == 0 && m.y == 0) begin
			th = 0;
			u = 0;
		end
		if (u < 0) u = 0;
		num = longint'(m.da) * TURN + 11520;
		if (num >= 0) q = num / 23040;
		else q = -((-num + 23039) / 23040);
		th = (th + q) & (TURN - 1);
		r = inv_gain(u) + longint'(m.dr) * 256;
		s = inv_gain(r);
		a = th >= HALF ? th - TURN : th;
		if (a > QUARTER) begin
			a -= HALF;
			s = -s;
		end else if (a < -QUARTER) begin
			a += HALF;
			s = -s;
		end
		u = s;
		v = 0;
		for (int i = 0; i < STAGES; i++) begin
			if (a >= 0) begin
				nu = u - floor_shr(v, i);
				nv = v + floor_shr(u, i);
				a -= atan_step(i);
			end else begin
				nu = u + floor_shr(v, i);
				nv = v - floor_shr(u, i);
				a += atan_step(i);
			end
			u = nu;
			v = nv;
		end
		rx = clamp_out(v, sat);
		ry = clamp_out(u, sat);
		p.x = rx[CW-1:0];
		p.y = ry[CW-1:0];
		p.z = m.z;
		p.e = m.e;
		p.sat = sat;
		return p;
	endfunction

	class move_board;
		point_t pending[$];
		int errors;
		int checked;

		function void note_move(move_t m);
			pending.push_back(polar_move(m));
		endfunction

		function void check_point(point_t got);
			point_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat x=%0d y=%0d", $time, got.x, got.y);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.x !== want.x) begin
				$display("%0t: x_out expected %0d actual %0d", $time, want.x, got.x);
				errors++;
			end
			if (got.y !== want.y) begin
				$display("%0t: y_out expected %0d actual %0d", $time, want.y, got.y);
				errors++;
			end
			if (got.z !== want.z) begin
				$display("%0t: z_out expected %0d actual %0d", $time, want.z, got.z);
				errors++;
			end
			if (got.e !== want.e) begin
				$display("%0t: e_out expected %0d actual %0d", $time, want.e, got.e);
				errors++;
			end
			if (got.sat !== want.sat) begin
				$display("%0t: saturated expected %0b actual %0b", $time, want.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_ready;
	logic signed [CW-1:0] x_in = 0, y_in = 0, z_in = 0, e_in = 0, radius_change = 0;
	logic signed [15:0] angle_change = 0;
	logic rsp_valid;
	logic rsp_ready = 0;
	logic signed [CW-1:0] x_out, y_out, z_out, e_out;
	logic saturated;

	int send_idle = 0;
	int recv_stall = 0;
	move_board board;

	polar_rotate_and_extend #(.COORD_WIDTH(CW), .CORDIC_STAGES(STAGES)) uut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				board.check_point('{x_out, y_out, z_out, e_out, saturated});
			rsp_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(5))
			0: return CW'($urandom_range(511) - 256);
			1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			2: return CW'($urandom_range(65535) - 32768);
			default: return CW'($urandom);
		endcase
	endfunction

	task automatic send_move(move_t m);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		x_in <= m.x;
		y_in <= m.y;
		z_in <= m.z;
		e_in <= m.e;
		angle_change <= m.da;
		radius_change <= m.dr;
		do @(posedge clk); while (!req_ready);
		board.note_move(m);
	endtask

	task automatic send_random(int n);
		move_t m;
		for (int i = 0; i < n; i++) begin
			m.x = rand_coord();
			m.y = rand_coord();
			if ($urandom_range(19) == 0) begin
				m.x = '0;
				m.y = '0;
			end
			m.z = CW'($urandom);
			m.e = CW'($urandom);
			m.da = $urandom_range(1) ? 16'($urandom_range(46080) - 23040) : 16'($urandom);
			m.dr = rand_coord();
			send_move(m);
		end
	endtask

	task automatic drain();
		req_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		move_t m;
		logic signed [CW-1:0] ext[4];
		ext = '{24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd1};
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: origin, extremes, wrap, negative radius
		foreach (ext[i]) begin
			m = '{ext[i], ext[3 - i], ext[i], ext[3 - i], 16'sd23040, ext[(i + 1) % 4]};
			send_move(m);
			m = '{ext[i], ext[i], -24'sd1, 24'sd5, -16'sd23040, ext[3 - i]};
			send_move(m);
		end
		send_move('{24'sd0, 24'sd0, 24'sd1, 24'sd2, 16'sd5760, 24'sd25600});
		send_move('{24'sd0, 24'sd0, 24'sd3, 24'sd4, 16'sd0, -24'sd25600});
		send_move('{24'sd2560, 24'sd0, 24'sd0, 24'sd0, 16'sh7FFF, -24'sd10000});
		send_move('{24'sd0, -24'sd2560, 24'sd0, 24'sd0, 16'sh8000, 24'sd0});
		send_move('{-24'sd300, 24'sd400, 24'sd0, 24'sd0, 16'sd11520, 24'sd0});
		send_move('{24'sd100, 24'sd100, 24'sd0, 24'sd0, -16'sd11520, 24'sh7FFFFF});
		send_move('{24'sh7FFFFF, 24'sh7FFFFF, 24'sd0, 24'sd0, 16'sd2880, 24'sh7FFFFF});
		send_move('{24'sh800000, 24'sh800000, 24'sd0, 24'sd0, -16'sd2880, 24'sh800000});
		send_random(400);
		drain();
		send_idle = 67;
		send_random(400);
		send_idle = 0;
		recv_stall = 67;
		send_random(400);
		send_idle = 28;
		recv_stall = 28;
		send_random(200);
		drain();
		send_random(300);
		drain();
		$display("checked %0d polar moves over four handshake pressure phases", board.checked);
		$display("covered origin, full-scale points, angle wrap and output clamping");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/pre_pkg.sv
src/pre_fifo.sv
src/pre_front.sv
src/pre_back.sv
src/polar_rotate_and_extend.sv
tb/tb.sv
